FILE: hw/rtl/sqe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack/queue engine package
// Shared widths, command codes, status codes and register map.
// ----------------------------------------------------------------------------
package sqe_pkg;

  localparam int DEFAULT_DEPTH = 64;

  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [DATA_W-1:0]   data_t;

  // Commands.
  localparam cmd_t CMD_PUSH = 3'd0;
  localparam cmd_t CMD_POP  = 3'd1;
  localparam cmd_t CMD_SWAP = 3'd2;
  localparam cmd_t CMD_PEEK = 3'd3;
  localparam cmd_t CMD_DUMP = 3'd4;

  // Result status codes.
  localparam status_t STATUS_OK       = 3'd0;
  localparam status_t STATUS_EMPTY    = 3'd1;
  localparam status_t STATUS_SHORT    = 3'd2;
  localparam status_t STATUS_FULL     = 3'd3;
  localparam status_t STATUS_NO_ITEMS = 3'd4;

  // Register index (byte address divided by four).
  localparam logic REG_INSERT_MODE = 1'b0;

  // Insert modes.
  localparam logic MODE_STACK = 1'b0;
  localparam logic MODE_QUEUE = 1'b1;

endpackage

FILE: hw/rtl/stack_queue_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack/queue engine
// Bounded ring of signed 32-bit entries with stack, queue, swap, peek and dump.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Signals                                    Contents
//  --------  ---  -----------------------------------------  -------------------
//  command   in   s_tvalid s_tready s_tdata s_tuser          value, command
//  result    out  m_tvalid m_tready m_tdata m_tuser m_tlast  result_value, status,
//                                                            last
//  config    in   psel penable pwrite paddr pwdata prdata    insert_mode at 0x0
//                 pready
//
//  Push and every failed command complete in the idle state; pop and peek pass
//  through ST_RESULT, swap through ST_SWAP_A, ST_SWAP_B and ST_SWAP_DONE, and
//  dump stays in ST_DUMP for each item, all set by the single entry memory.
//  Reset (synchronous, rst high) empties the store and selects stack mode; the
//  entry memory is not cleared, since only written entries are ever read.
//  A stall on the result side holds the engine in a step that loads the result
//  register (ST_RESULT, ST_SWAP_DONE, ST_DUMP); the command side takes a new
//  transfer only when the engine is idle and the result register is free or is being taken in the same cycle.
//
module stack_queue_engine #(
  parameter int DEPTH = sqe_pkg::DEFAULT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  // Command stream.
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [sqe_pkg::DATA_W-1:0]   s_tdata,   // [31:0] value
  input  logic [sqe_pkg::CMD_W-1:0]    s_tuser,   // [2:0] command
  // Result stream.
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [sqe_pkg::DATA_W-1:0]   m_tdata,   // [31:0] result_value
  output logic [sqe_pkg::STATUS_W-1:0] m_tuser,   // [2:0] status
  output logic                         m_tlast,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sqe_pkg::PADDR_W-1:0]  paddr,
  input  logic [sqe_pkg::PDATA_W-1:0]  pwdata,
  output logic [sqe_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  import sqe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [AW:0]   DEPTH_W  = DEPTH[AW:0];
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  // Engine states.
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_RESULT    = 3'd1;
  localparam logic [2:0] ST_SWAP_A    = 3'd2;
  localparam logic [2:0] ST_SWAP_B    = 3'd3;
  localparam logic [2:0] ST_SWAP_DONE = 3'd4;
  localparam logic [2:0] ST_DUMP      = 3'd5;

  // Entry memory: one write and one registered read per cycle.
  data_t          mem [DEPTH];
  data_t          rd_data;
  logic           mem_we;
  logic           mem_re;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  data_t          wdata;

  // Control and bookkeeping registers.
  logic [2:0]     state, state_next;
  logic [AW-1:0]  front, front_next;
  logic [CW-1:0]  count, count_next;
  logic [AW-1:0]  dump_k, dump_k_next;
  data_t          swap_tmp, swap_tmp_next;
  logic           insert_mode;

  // Result register.
  logic           out_load;
  data_t          out_value;
  status_t        out_status;
  logic           out_last;

  logic           out_free;
  logic           accept;
  logic           cfg_write;
  logic [AW-1:0]  front_inc;
  logic [AW-1:0]  front_dec;
  logic [AW-1:0]  second_idx;
  logic           dump_last;

  // Ring position k places behind the front; k stays below DEPTH, so one
  // conditional subtract brings the sum back into range.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [AW-1:0] k);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, k};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == ST_IDLE) && out_free;
  assign accept     = s_tvalid && s_tready;

  assign front_inc  = (front == LAST_IDX) ? '0 : front + AW'(1);
  assign front_dec  = (front == '0) ? LAST_IDX : front - AW'(1);
  assign second_idx = slot(front, AW'(1));
  assign dump_last  = ((CW'(dump_k) + CW'(1)) == count);

  // Configuration port: single register, always ready.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_INSERT_MODE);
  assign prdata    = (paddr[2] == REG_INSERT_MODE) ? {{(PDATA_W-1){1'b0}}, insert_mode}
                                                   : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      insert_mode <= MODE_STACK;
    end else if (cfg_write) begin
      insert_mode <= pwdata[0];
    end
  end

  // Sequencer: every command starts in the idle state; those that need stored
  // data issue a read there and finish in the following states.
  always_comb begin
    state_next    = state;
    front_next    = front;
    count_next    = count;
    dump_k_next   = dump_k;
    swap_tmp_next = swap_tmp;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    waddr         = front;
    raddr         = front;
    wdata         = s_tdata;
    out_load      = 1'b0;
    out_value     = '0;
    out_status    = STATUS_OK;
    out_last      = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_tuser)
            CMD_PUSH: begin
              out_load = 1'b1;
              if (count >= DEPTH_C) begin
                out_status = STATUS_FULL;
              end else begin
                mem_we     = 1'b1;
                count_next = count + CW'(1);
                if (insert_mode == MODE_STACK) begin
                  front_next = front_dec;
                  waddr      = front_dec;
                end else begin
                  waddr = slot(front, count[AW-1:0]);
                end
              end
            end
            CMD_POP: begin
              if (count == '0) begin
                out_load   = 1'b1;
                out_status = STATUS_EMPTY;
              end else begin
                mem_re     = 1'b1;
                front_next = front_inc;
                count_next = count - CW'(1);
                state_next = ST_RESULT;
              end
            end
            CMD_PEEK: begin
              if (count == '0) begin
                out_load   = 1'b1;
                out_status = STATUS_EMPTY;
              end else begin
                mem_re     = 1'b1;
                state_next = ST_RESULT;
              end
            end
            CMD_SWAP: begin
              if (count < CW'(2)) begin
                out_load   = 1'b1;
                out_status = STATUS_SHORT;
              end else begin
                mem_re     = 1'b1;
                state_next = ST_SWAP_A;
              end
            end
            CMD_DUMP: begin
              if (count == '0) begin
                out_load   = 1'b1;
                out_status = STATUS_NO_ITEMS;
              end else begin
                mem_re      = 1'b1;
                dump_k_next = '0;
                state_next  = ST_DUMP;
              end
            end
            default: begin
              // Unknown commands are taken and dropped.
            end
          endcase
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_value  = rd_data;
          state_next = ST_IDLE;
        end
      end
      ST_SWAP_A: begin
        // Front entry arrives; fetch the second one.
        swap_tmp_next = rd_data;
        mem_re        = 1'b1;
        raddr         = second_idx;
        state_next    = ST_SWAP_B;
      end
      ST_SWAP_B: begin
        mem_we     = 1'b1;
        waddr      = front;
        wdata      = rd_data;
        state_next = ST_SWAP_DONE;
      end
      ST_SWAP_DONE: begin
        if (out_free) begin
          mem_we     = 1'b1;
          waddr      = second_idx;
          wdata      = swap_tmp;
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DUMP: begin
        // One entry per cycle while the result side keeps up; the next read
        // is issued as the current entry moves into the result register.
        if (out_free) begin
          out_load  = 1'b1;
          out_value = rd_data;
          out_last  = dump_last;
          if (dump_last) begin
            state_next = ST_IDLE;
          end else begin
            mem_re      = 1'b1;
            raddr       = slot(front, dump_k + AW'(1));
            dump_k_next = dump_k + AW'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    dump_k   <= dump_k_next;
    swap_tmp <= swap_tmp_next;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_value;
      m_tuser <= out_status;
      m_tlast <= out_last;
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack/queue engine testbench
// Drives command transfers into the engine and predicts every result transfer
// from its own copy of the ring, front index, item count and insert mode.
// Each result is checked field by field against the oldest prediction. A
// short directed sequence comes first, then random sequences that fill the
// ring to full and drain it again, under several idle and stall patterns and
// in both insert modes.
// ----------------------------------------------------------------------------
module tb;
  import sqe_pkg::*;

  localparam int DEPTH = DEFAULT_DEPTH;

  // The longest command is a dump of a full ring, so this margin covers any
  // work still in flight after the last predicted result, such as an ignored
  // command.
  localparam int SETTLE_CYCLES = 2 * DEPTH + 16;

  // Cycle budget for the whole run. The slowest correct run has every command
  // produce a full dump under heavy stalls, plus the long receiver hold-off.
  localparam int CYCLE_LIMIT = 400_000;

  localparam int HOLD_OFF_CYCLES = 300;

  // Byte address of the insert mode register (register index times four).
  localparam logic [PADDR_W-1:0] INSERT_MODE_ADDR = {REG_INSERT_MODE, 2'b00};

  // One result transfer as seen on the master side.
  typedef struct {
    data_t   value;
    status_t status;
    logic    last_flag;
  } result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds the predicted ring and the results still awaited.
  // --------------------------------------------------------------------------
  class ring_scoreboard;
    data_t   store [DEPTH];
    int      head;
    int      fill;
    logic    queue_mode;
    result_t awaited_results [$];
    int      mismatches;

    function new();
      head       = 0;
      fill       = 0;
      queue_mode = MODE_STACK;
      mismatches = 0;
    endfunction

    function void add_result(data_t value, status_t status, logic last_flag);
      result_t r;
      r.value     = value;
      r.status    = status;
      r.last_flag = last_flag;
      awaited_results.push_back(r);
    endfunction

    // Updates the predicted ring for one accepted command and queues the
    // results that the command must produce.
    function void apply_command(cmd_t cmd, data_t value);
      data_t held;
      int    second;
      case (cmd)
        CMD_PUSH: begin
          if (fill == DEPTH) begin
            add_result('0, STATUS_FULL, 1'b1);
          end else begin
            if (queue_mode == MODE_STACK) begin
              head        = (head + DEPTH - 1) % DEPTH;
              store[head] = value;
            end else begin
              store[(head + fill) % DEPTH] = value;
            end
            fill++;
            add_result('0, STATUS_OK, 1'b1);
          end
        end
        CMD_POP: begin
          if (fill == 0) begin
            add_result('0, STATUS_EMPTY, 1'b1);
          end else begin
            held = store[head];
            head = (head + 1) % DEPTH;
            fill--;
            add_result(held, STATUS_OK, 1'b1);
          end
        end
        CMD_SWAP: begin
          if (fill < 2) begin
            add_result('0, STATUS_SHORT, 1'b1);
          end else begin
            second        = (head + 1) % DEPTH;
            held          = store[head];
            store[head]   = store[second];
            store[second] = held;
            add_result('0, STATUS_OK, 1'b1);
          end
        end
        CMD_PEEK: begin
          if (fill == 0) add_result('0, STATUS_EMPTY, 1'b1);
          else add_result(store[head], STATUS_OK, 1'b1);
        end
        CMD_DUMP: begin
          if (fill == 0) begin
            add_result('0, STATUS_NO_ITEMS, 1'b1);
          end else begin
            for (int k = 0; k < fill; k++)
              add_result(store[(head + k) % DEPTH], STATUS_OK, k == fill - 1);
          end
        end
        default: begin
          // Unused command codes are dropped without a result.
        end
      endcase
    endfunction

    // Compares one result transfer with the oldest prediction.
    function void compare_result(data_t value, status_t status, logic last_flag);
      result_t want;
      if (awaited_results.size() == 0) begin
        $error("result with none awaited: result_value %h status %0d last %0b",
               value, status, last_flag);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      if (value !== want.value) begin
        $error("result_value mismatch: expected %h, got %h", want.value, value);
        mismatches++;
      end
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, status);
        mismatches++;
      end
      if (last_flag !== want.last_flag) begin
        $error("last mismatch: expected %0b, got %0b", want.last_flag, last_flag);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block signals. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  data_t                s_tdata  = '0;   // [31:0] value
  cmd_t                 s_tuser  = CMD_PUSH; // [2:0] command
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  data_t                m_tdata;         // [31:0] result_value
  status_t              m_tuser;         // [2:0] status
  logic                 m_tlast;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [PADDR_W-1:0]   paddr    = '0;
  logic [PDATA_W-1:0]   pwdata   = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stack_queue_engine #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ring_scoreboard sb = new();

  // Percentages of cycles in which the sender idles and the receiver stalls.
  // The main sequence changes them from phase to phase.
  int   idle_pct     = 0;
  int   stall_pct    = 0;
  logic hold_request = 1'b0;
  int   hold_left    = 0;
  int   cycle_count  = 0;

  // --------------------------------------------------------------------------
  // Monitor. All inputs change only through nonblocking assignments at the
  // rising edge, so the values read here are the ones present at the edge.
  // A result transfer always belongs to an earlier command, so it is checked
  // before a command transfer of the same edge is applied to the prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.compare_result(m_tdata, m_tuser, m_tlast);
      if (s_tvalid && s_tready) sb.apply_command(s_tuser, s_tdata);
      if (psel && penable && pwrite && pready && paddr == INSERT_MODE_ADDR)
        sb.queue_mode = pwdata[0];
    end
  end

  // Receiver. Stalls at random, or holds off entirely for a long stretch when
  // asked, so that the engine backs up and stops taking commands.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers.
  // --------------------------------------------------------------------------

  // Offers one command transfer and returns at the edge where it is taken.
  // Valid is left high, so the next command can follow without a gap.
  task automatic send_command(cmd_t cmd, data_t value);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops offering commands until every predicted result has arrived, then
  // lets the given number of further cycles pass.
  task automatic await_results(int extra_cycles);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.awaited_results.size() != 0);
    repeat (extra_cycles) @(posedge clk);
  endtask

  // Setup cycle, then access cycle until pready.
  task automatic write_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Changes the insert mode only once the engine has gone quiet.
  task automatic set_insert_mode(logic mode);
    await_results(SETTLE_CYCLES);
    write_register(INSERT_MODE_ADDR, {{(PDATA_W-1){1'b0}}, mode});
  endtask

  // Mostly random data, with the signed extremes, zero and minus one mixed in.
  function automatic data_t pick_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // The random part alternates between filling the ring until several
  // pushes have hit a full ring, and draining it until it is empty again.
  // That keeps the full, empty and short cases coming up repeatedly.
  bit filling   = 1'b1;
  int full_hits = 0;

  function automatic cmd_t pick_command();
    int roll;
    if (filling && sb.fill == DEPTH && full_hits >= 3) begin
      filling   = 1'b0;
      full_hits = 0;
    end else if (!filling && sb.fill == 0) begin
      filling = 1'b1;
    end
    roll = $urandom_range(99);
    // A few unused command codes as noise.
    if (roll < 3) return cmd_t'(CMD_DUMP + 1 + $urandom_range(2));
    if (filling) begin
      if (roll < 85) begin
        if (sb.fill == DEPTH) full_hits++;
        return CMD_PUSH;
      end
      if (roll < 90) return CMD_POP;
      if (roll < 94) return CMD_SWAP;
      if (roll < 97) return CMD_PEEK;
      return CMD_DUMP;
    end
    if (roll < 13) return CMD_PUSH;
    if (roll < 67) return CMD_POP;
    if (roll < 78) return CMD_SWAP;
    if (roll < 89) return CMD_PEEK;
    return CMD_DUMP;
  endfunction

  // One phase of random commands. Optionally the receiver is told to hold
  // off partway through, or the sender pauses until everything has drained.
  task automatic run_random(int count, bit with_hold_off, bit with_pause);
    for (int i = 0; i < count; i++) begin
      if (with_hold_off && i == count / 3) hold_request = 1'b1;
      if (with_pause && i == count / 2) await_results(0);
      send_command(pick_command(), pick_value());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Stack mode, written explicitly, for the directed part.
    write_register(INSERT_MODE_ADDR, {{(PDATA_W-1){1'b0}}, MODE_STACK});

    // Every failing case on an empty ring, then the unused command codes.
    send_command(CMD_POP,  32'h1234_5678);
    send_command(CMD_PEEK, 32'hFFFF_FFFF);
    send_command(CMD_SWAP, '0);
    send_command(CMD_DUMP, '0);
    for (int c = CMD_DUMP + 1; c < 8; c++) send_command(cmd_t'(c), $urandom);
    // One entry: swap is still short, peek and dump see a single value.
    send_command(CMD_PUSH, 32'h7FFF_FFFF);
    send_command(CMD_SWAP, '0);
    send_command(CMD_PEEK, '0);
    send_command(CMD_DUMP, '0);
    // Several entries with the extremes, a swap, a dump, then pop past empty.
    send_command(CMD_PUSH, 32'h8000_0000);
    send_command(CMD_PUSH, 32'h0000_0000);
    send_command(CMD_PUSH, 32'hFFFF_FFFF);
    send_command(CMD_SWAP, '0);
    send_command(CMD_DUMP, '0);
    send_command(CMD_PEEK, '0);
    for (int i = 0; i < 5; i++) send_command(CMD_POP, '0);

    // Queue mode, no idling, with the long receiver hold-off.
    idle_pct  = 0;
    stall_pct = 0;
    set_insert_mode(MODE_QUEUE);
    run_random(80, 1'b1, 1'b0);

    // Stack mode, sender idling, with a pause until all results are in.
    idle_pct  = 49;
    stall_pct = 0;
    set_insert_mode(MODE_STACK);
    run_random(80, 1'b0, 1'b1);

    // Queue mode, receiver stalling.
    idle_pct  = 0;
    stall_pct = 49;
    set_insert_mode(MODE_QUEUE);
    run_random(75, 1'b0, 1'b0);

    // Stack mode, both sides idling.
    idle_pct  = 29;
    stall_pct = 29;
    set_insert_mode(MODE_STACK);
    run_random(75, 1'b0, 1'b0);

    await_results(SETTLE_CYCLES);
    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
